// File: hw/rtl/sfe_pkg.sv
package sfe_pkg;

	// Strip geometry
	localparam int MAX_PIXELS = 64;
	localparam int IDX_W      = 6;
	localparam int CNT_W      = 7;

	// Field widths
	localparam int COLOR_W = 8;
	localparam int SPEED_W = 6;
	localparam int RAND_W  = 32;
	localparam int ACC_W   = 7;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	// Frame constants
	localparam logic [ACC_W-1:0]   SPARKLE_PERIOD = 7'd60;
	localparam logic [COLOR_W-1:0] FULL_LEVEL     = 8'd255;
	localparam logic [SPEED_W-1:0] SPEED_MIN      = 6'd1;
	localparam logic [SPEED_W-1:0] SPEED_MAX      = 6'd40;
	localparam logic [CNT_W-1:0]   COUNT_MIN      = 7'd2;
	localparam logic [CNT_W-1:0]   COUNT_MAX      = CNT_W'(MAX_PIXELS);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RED    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GREEN  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLUE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RATE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd6;

	// Controller to datapath commands
	typedef struct packed {
		logic load_frame;
		logic div_start;
		logic div_second;
		logic off_load;
		logic pos_load;
		logic pix_rd;
		logic pix_wr;
	} sfe_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic enabled;
		logic acc_zero;
		logic div_done;
		logic last_pix;
		logic out_free;
	} sfe_sts_t;

endpackage

// File: hw/rtl/sfe_div.sv
module sfe_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [sfe_pkg::RAND_W-1:0]       dividend,
	input  logic [sfe_pkg::CNT_W-1:0]        divisor,
	output logic                             done,
	output logic [sfe_pkg::IDX_W-1:0]        remainder
);

	localparam int STEP_W = $clog2(sfe_pkg::RAND_W);

	logic                          busy_q;
	logic                          done_q;
	logic [STEP_W-1:0]             step_q;
	logic [sfe_pkg::RAND_W-1:0]    dvd_q;
	logic [sfe_pkg::CNT_W-1:0]     dvs_q;
	logic [sfe_pkg::IDX_W-1:0]     rem_q;
	logic [sfe_pkg::CNT_W-1:0]     trial;
	logic [sfe_pkg::IDX_W-1:0]     rem_next;

	// Shift in one dividend bit and subtract when it fits
	always_comb begin
		trial = {rem_q, dvd_q[sfe_pkg::RAND_W-1]};
		if (trial >= dvs_q) begin
			rem_next = sfe_pkg::IDX_W'(trial - dvs_q);
		end else begin
			rem_next = trial[sfe_pkg::IDX_W-1:0];
		end
	end

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(sfe_pkg::RAND_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand and partial remainder registers
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[sfe_pkg::RAND_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

// File: hw/rtl/sfe_dp.sv
module sfe_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [sfe_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sfe_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic [sfe_pkg::RAND_W-1:0]          random_word,
	input  sfe_pkg::sfe_cmd_t                   cmd,
	output sfe_pkg::sfe_sts_t                   sts,
	input  logic                                out_stall,
	output logic                                out_valid,
	output logic [sfe_pkg::IDX_W-1:0]           pixel_index,
	output logic [sfe_pkg::COLOR_W-1:0]         red_out,
	output logic [sfe_pkg::COLOR_W-1:0]         green_out,
	output logic [sfe_pkg::COLOR_W-1:0]         blue_out,
	output logic                                last_pixel
);

	// Video scaling: ((x * s) >> 8) + 1 unless either is zero
	function automatic logic [7:0] video_scale(input logic [7:0] x, input logic [7:0] s);
		logic [15:0] p;
		p = 16'(x) * 16'(s);
		return p[15:8] + 8'((x != 8'd0) && (s != 8'd0));
	endfunction

	// Brightness scaling: (x * (k + 1)) >> 8
	function automatic logic [7:0] bright_scale(input logic [7:0] x, input logic [7:0] k);
		logic [16:0] p;
		p = 17'(x) * (17'(k) + 17'd1);
		return p[15:8];
	endfunction

	// Configuration registers
	logic [sfe_pkg::COLOR_W-1:0] red_q, green_q, blue_q, gain_q;
	logic [sfe_pkg::SPEED_W-1:0] rate_q;
	logic [sfe_pkg::CNT_W-1:0]   count_q;
	logic                        run_q;

	// Frame state
	logic [sfe_pkg::ACC_W-1:0]   acc_q;
	logic [sfe_pkg::IDX_W-1:0]   pos_q;
	logic [sfe_pkg::IDX_W-1:0]   off_q;
	logic                        sparkle_q;
	logic [sfe_pkg::RAND_W-1:0]  rand_q;
	logic [sfe_pkg::CNT_W-1:0]   n_q;
	logic [sfe_pkg::SPEED_W-1:0] fade_q;
	logic [sfe_pkg::COLOR_W-1:0] base_r_q, base_g_q, base_b_q;
	logic [sfe_pkg::IDX_W-1:0]   pix_q;

	// Brightness store
	logic [sfe_pkg::COLOR_W-1:0]    mem [sfe_pkg::MAX_PIXELS];
	logic [sfe_pkg::MAX_PIXELS-1:0] written_q;
	logic [sfe_pkg::COLOR_W-1:0]    rd_data_q;
	logic                           rd_written_q;

	// Output register
	logic                        out_valid_q;
	logic [sfe_pkg::IDX_W-1:0]   idx_q;
	logic [sfe_pkg::COLOR_W-1:0] r_q, g_q, b_q;
	logic                        last_q;

	logic [sfe_pkg::SPEED_W-1:0] speed;
	logic [sfe_pkg::CNT_W-1:0]   n_clamp;
	logic [sfe_pkg::ACC_W-1:0]   acc_sum;
	logic [sfe_pkg::RAND_W-1:0]  div_dividend;
	logic [sfe_pkg::CNT_W-1:0]   div_divisor;
	logic                        div_done;
	logic [sfe_pkg::IDX_W-1:0]   div_rem;
	logic [sfe_pkg::CNT_W-1:0]   pos_sum;
	logic [sfe_pkg::COLOR_W-1:0] old_k;
	logic [sfe_pkg::COLOR_W-1:0] new_k;
	logic                        is_last;
	logic                        out_free;

	// Clamp speed and pixel count
	always_comb begin
		if (rate_q < sfe_pkg::SPEED_MIN) begin
			speed = sfe_pkg::SPEED_MIN;
		end else if (rate_q > sfe_pkg::SPEED_MAX) begin
			speed = sfe_pkg::SPEED_MAX;
		end else begin
			speed = rate_q;
		end
		if (count_q < sfe_pkg::COUNT_MIN) begin
			n_clamp = sfe_pkg::COUNT_MIN;
		end else if (count_q > sfe_pkg::COUNT_MAX) begin
			n_clamp = sfe_pkg::COUNT_MAX;
		end else begin
			n_clamp = count_q;
		end
		acc_sum = acc_q + sfe_pkg::ACC_W'(speed);
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_q   <= 8'd255;
			green_q <= 8'd255;
			blue_q  <= 8'd255;
			gain_q  <= 8'd255;
			rate_q  <= 6'd1;
			count_q <= 7'd60;
			run_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sfe_pkg::REG_RED:    red_q   <= cfg_data;
				sfe_pkg::REG_GREEN:  green_q <= cfg_data;
				sfe_pkg::REG_BLUE:   blue_q  <= cfg_data;
				sfe_pkg::REG_GAIN:   gain_q  <= cfg_data;
				sfe_pkg::REG_RATE:   rate_q  <= cfg_data[sfe_pkg::SPEED_W-1:0];
				sfe_pkg::REG_COUNT:  count_q <= cfg_data[sfe_pkg::CNT_W-1:0];
				sfe_pkg::REG_ENABLE: run_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Delay accumulator and sparkle position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			pos_q <= '0;
		end else begin
			if (cmd.load_frame) begin
				if (acc_q == '0 || acc_sum < sfe_pkg::SPARKLE_PERIOD) begin
					acc_q <= acc_sum;
				end else begin
					acc_q <= '0;
				end
			end
			if (cmd.pos_load) begin
				pos_q <= div_rem;
			end
		end
	end

	// Capture per-frame operands
	always_ff @(posedge clk) begin
		if (cmd.load_frame) begin
			sparkle_q <= (acc_q == '0);
			rand_q    <= random_word;
			n_q       <= n_clamp;
			fade_q    <= speed + 1'b1;
			base_r_q  <= video_scale(red_q, gain_q);
			base_g_q  <= video_scale(green_q, gain_q);
			base_b_q  <= video_scale(blue_q, gain_q);
		end
		if (cmd.off_load) begin
			off_q <= div_rem + 1'b1;
		end
	end

	// Remainder unit: first random mod (n-1), then (pos + offset) mod n
	assign pos_sum      = sfe_pkg::CNT_W'(pos_q) + sfe_pkg::CNT_W'(off_q);
	assign div_dividend = cmd.div_second ? sfe_pkg::RAND_W'(pos_sum) : rand_q;
	assign div_divisor  = cmd.div_second ? n_q : n_q - 1'b1;

	sfe_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.remainder (div_rem)
	);

	// Pixel counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_q <= '0;
		end else if (cmd.load_frame) begin
			pix_q <= '0;
		end else if (cmd.pix_wr) begin
			pix_q <= pix_q + 1'b1;
		end
	end

	// Brightness store read and write
	always_ff @(posedge clk) begin
		if (cmd.pix_rd) begin
			rd_data_q    <= mem[pix_q];
			rd_written_q <= written_q[pix_q];
		end
		if (cmd.pix_wr) begin
			mem[pix_q] <= new_k;
		end
	end

	// Entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (cmd.pix_wr) begin
			written_q[pix_q] <= 1'b1;
		end
	end

	// Fade, or relight the sparkle pixel
	always_comb begin
		old_k = rd_written_q ? rd_data_q : '0;
		if (sparkle_q && pix_q == pos_q) begin
			new_k = sfe_pkg::FULL_LEVEL;
		end else if (old_k > sfe_pkg::COLOR_W'(fade_q)) begin
			new_k = old_k - sfe_pkg::COLOR_W'(fade_q);
		end else begin
			new_k = '0;
		end
		is_last  = (sfe_pkg::CNT_W'(pix_q) == n_q - 1'b1);
		out_free = !out_valid_q || !out_stall;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.pix_wr) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pix_wr) begin
			idx_q  <= pix_q;
			r_q    <= bright_scale(base_r_q, new_k);
			g_q    <= bright_scale(base_g_q, new_k);
			b_q    <= bright_scale(base_b_q, new_k);
			last_q <= is_last;
		end
	end

	assign sts.enabled  = run_q;
	assign sts.acc_zero = (acc_q == '0);
	assign sts.div_done = div_done;
	assign sts.last_pix = is_last;
	assign sts.out_free = out_free;

	assign out_valid   = out_valid_q;
	assign pixel_index = idx_q;
	assign red_out     = r_q;
	assign green_out   = g_q;
	assign blue_out    = b_q;
	assign last_pixel  = last_q;

endmodule

// File: hw/rtl/sfe_ctl.sv
module sfe_ctl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  sfe_pkg::sfe_sts_t sts,
	output sfe_pkg::sfe_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_DIV1_GO  = 3'd1;
	localparam logic [2:0] ST_DIV1_RUN = 3'd2;
	localparam logic [2:0] ST_DIV2_GO  = 3'd3;
	localparam logic [2:0] ST_DIV2_RUN = 3'd4;
	localparam logic [2:0] ST_PIX_RD   = 3'd5;
	localparam logic [2:0] ST_PIX_WR   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && sts.enabled) begin
					cmd.load_frame = 1'b1;
					state_d = sts.acc_zero ? ST_DIV1_GO : ST_PIX_RD;
				end
			end
			ST_DIV1_GO: begin
				cmd.div_start = 1'b1;
				state_d = ST_DIV1_RUN;
			end
			ST_DIV1_RUN: begin
				if (sts.div_done) begin
					cmd.off_load = 1'b1;
					state_d = ST_DIV2_GO;
				end
			end
			ST_DIV2_GO: begin
				cmd.div_start  = 1'b1;
				cmd.div_second = 1'b1;
				state_d = ST_DIV2_RUN;
			end
			ST_DIV2_RUN: begin
				if (sts.div_done) begin
					cmd.pos_load = 1'b1;
					state_d = ST_PIX_RD;
				end
			end
			ST_PIX_RD: begin
				cmd.pix_rd = 1'b1;
				state_d = ST_PIX_WR;
			end
			ST_PIX_WR: begin
				if (sts.out_free) begin
					cmd.pix_wr = 1'b1;
					state_d = sts.last_pix ? ST_IDLE : ST_PIX_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

endmodule

// File: hw/rtl/led_sparkle_frame_engine.sv
// An accepted frame tick starts with a brightness store read; on a sparkle frame two
// bit-serial remainder runs first pick the new position. Each pixel takes a brightness
// store read, then write-back and output load; write-back waits while the output stalls,
// and new ticks are stalled until the last pixel of the frame is written. A tick taken
// while disabled is dropped. Reset is asynchronous: configuration and control registers
// return to defaults and the brightness store reads as zero until each pixel is rewritten.
module led_sparkle_frame_engine (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [sfe_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sfe_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [sfe_pkg::RAND_W-1:0]          random_word,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [sfe_pkg::IDX_W-1:0]           pixel_index,
	output logic [sfe_pkg::COLOR_W-1:0]         red_out,
	output logic [sfe_pkg::COLOR_W-1:0]         green_out,
	output logic [sfe_pkg::COLOR_W-1:0]         blue_out,
	output logic                                last_pixel
);

	sfe_pkg::sfe_cmd_t cmd;
	sfe_pkg::sfe_sts_t sts;

	sfe_ctl u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	sfe_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.random_word (random_word),
		.cmd         (cmd),
		.sts         (sts),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.pixel_index (pixel_index),
		.red_out     (red_out),
		.green_out   (green_out),
		.blue_out    (blue_out),
		.last_pixel  (last_pixel)
	);

endmodule
